/* rtl/core/assert_macros.svh */
// assertion macros included by moving_average_hysteresis_switch.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CHK_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CHK_PROP(lbl, clk, rst_n, prop, msg)
`define CHK_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/mahs_pkg.sv */
// shared constants and types of the moving average switch
`default_nettype none

package mahs_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int THR_W          = 12;
  localparam int WINDOW_DEPTH_DEF = 16;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_DARK  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIGHT = 1'd1;

  localparam logic [THR_W-1:0] DARK_RESET  = 12'd1000;
  localparam logic [THR_W-1:0] LIGHT_RESET = 12'd2000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/core/mahs_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module mahs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mahs_divider.sv */
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module mahs_divider #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DVD_W-1:0]    dividend,
  input  wire logic [DVS_W-1:0]    divisor,
  output logic      [DVD_W-1:0]    quotient,
  output mahs_pkg::div_stat_t      stat
);

  import mahs_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W:0]   diff;
  logic [DVS_W-1:0] rem_nxt;

  // dividend bits shift out at the top while quotient bits shift in below
  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    fits    = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

/* rtl/core/mahs_cfg.sv */
// threshold registers behind the apb-style configuration port
`default_nettype none

module mahs_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mahs_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [mahs_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [mahs_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output logic      [mahs_pkg::THR_W-1:0]          dark_thr,
  output logic      [mahs_pkg::THR_W-1:0]          light_thr
);

  import mahs_pkg::*;

  logic [THR_W-1:0]     dark_r;
  logic [THR_W-1:0]     light_r;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r  <= DARK_RESET;
      light_r <= LIGHT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_DARK:  dark_r  <= pwdata[THR_W-1:0];
        REG_LIGHT: light_r <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DARK:  prdata = CFG_DATA_W'(dark_r);
      REG_LIGHT: prdata = CFG_DATA_W'(light_r);
      default:   prdata = '0;
    endcase
  end

  assign dark_thr  = dark_r;
  assign light_thr = light_r;

endmodule

`default_nettype wire

/* rtl/core/moving_average_hysteresis_switch.sv */
// moving average of light samples with a hysteresis switch
//
// in_sample comes in on a valid/stall channel; each item gives one result
// on out_average and out_switch_on. The window of the last WINDOW_DEPTH
// samples sits in a ram; a running sum is updated once per item and then
// divided by the count of valid samples in a bit-serial divider.
// The running sum is SUM_W = 12 + clog2(WINDOW_DEPTH) bits wide. A new
// item is not taken until the result of the last one has gone into the
// output register; the divider works out one quotient bit per cycle.
// The output register holds a finished result while out_stall is high; the
// next item is still accepted and worked on, and its result waits in the
// divider until the output register is free.
// Thresholds are written through the apb-style port (dark at 0x0, light at
// 0x4) while the block is idle; the user must keep to this, the block
// itself does not enforce it. Synchronous reset clears the sum, count,
// pointer and switch and restores thresholds 1000 and 2000; no clearing
// pass runs, the fill count masks unwritten window entries.
`default_nettype none

`include "assert_macros.svh"

module moving_average_hysteresis_switch #(
  parameter int WINDOW_DEPTH = mahs_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mahs_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [mahs_pkg::SAMPLE_W-1:0]   out_average,
  output logic                                 out_switch_on,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mahs_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [mahs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [mahs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  import mahs_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                sw_r, sw_nxt;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic                out_sw_r;

  logic [THR_W-1:0]    dark_thr;
  logic [THR_W-1:0]    light_thr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SUM_W-1:0]    quotient;
  div_stat_t           div_stat;

  logic                accept_in;
  logic                full;
  logic [SAMPLE_W-1:0] old_val;
  logic                out_free;
  logic                load_out;
  logic [SAMPLE_W-1:0] mean;

  mahs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .dark_thr  (dark_thr),
    .light_thr (light_thr)
  );

  mahs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .we      (state_r == ST_UPD),
    .waddr   (wr_ptr_r),
    .wdata   (sample_r),
    .re      (accept_in),
    .raddr   (wr_ptr_r),
    .rdata_r (ram_rdata)
  );

  mahs_divider #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_UPD),
    .dividend (sum_nxt),
    .divisor  (cnt_nxt),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept_in = in_valid && (state_r == ST_IDLE);
  assign full      = (cnt_r == CNT_W'(WINDOW_DEPTH));
  // until the window has filled, the slot being replaced was never written
  assign old_val   = full ? ram_rdata : '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (state_r == ST_DIV) && div_stat.done && out_free;
  assign mean      = quotient[SAMPLE_W-1:0];

  always_comb begin
    sum_nxt    = sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
    cnt_nxt    = full ? cnt_r : cnt_r + 1'b1;
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;

    if (!sw_r && (mean < dark_thr)) begin
      sw_nxt = 1'b1;
    end else if (sw_r && (mean > light_thr)) begin
      sw_nxt = 1'b0;
    end else begin
      sw_nxt = sw_r;
    end

    case (state_r)
      ST_IDLE: state_nxt = accept_in ? ST_UPD : ST_IDLE;
      ST_UPD:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = load_out ? ST_IDLE : ST_DIV;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      sw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_UPD) begin
        wr_ptr_r <= wr_ptr_nxt;
        cnt_r    <= cnt_nxt;
        sum_r    <= sum_nxt;
      end
      if (load_out) begin
        sw_r        <= sw_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      sample_r <= in_sample;
    end
    if (load_out) begin
      out_avg_r <= mean;
      out_sw_r  <= sw_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_average   = out_avg_r;
  assign out_switch_on = out_sw_r;

  `CHK_PROP(a_accept_to_upd, clk, rst_n, (in_valid && !in_stall) |=> (state_r == ST_UPD), "accepted item did not start the sum update")
  `CHK_PROP(a_out_from_div, clk, rst_n, $rose(out_valid) |-> $past((state_r == ST_DIV) && div_stat.done), "result shown without a finished division")
  `CHK_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_W'(WINDOW_DEPTH), "valid count beyond window depth")
  `CHK_PROP(a_ptr_follows_cnt, clk, rst_n, (cnt_r < CNT_W'(WINDOW_DEPTH)) |-> (wr_ptr_r == cnt_r[PTR_W-1:0]), "write pointer out of step with fill count")

endmodule

`default_nettype wire
